// ===== src/pva_pkg.sv =====
// Shared types and constants for the polyphonic voice allocator.
`timescale 1ns / 1ps

package pva_pkg;

  localparam int NumVoicesDef = 16;
  localparam int LevelBitsDef = 16;

  localparam logic [1:0] MODE_ON     = 2'd0;
  localparam logic [1:0] MODE_OFF    = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SOUND = 2'd1;
  localparam logic [1:0] PH_REL   = 2'd2;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  localparam logic [7:0] NOTE_NONE = 8'd128;

  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_STATUS
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [3:0] sel;
    logic       sel_ok;
    logic [1:0] phase;
  } cmd_t;

  localparam int CmdBits = $bits(cmd_t);

endpackage

// ===== src/pva_front.sv =====
// Front end: takes events, decodes the mode and converts the reported level.
`timescale 1ns / 1ps

module pva_front import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef,
  parameter int LEVEL_BITS = LevelBitsDef
) (
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            mode,
  input  logic [6:0]            note,
  input  logic [6:0]            velocity,
  input  logic [3:0]            voice_sel,
  input  logic [1:0]            env_phase,
  input  logic [15:0]           env_level,
  output logic                  push,
  output cmd_t                  cmd,
  output logic [LEVEL_BITS-1:0] level
);

  logic                   known;
  logic [LEVEL_BITS+15:0] lvl_wide;

  always_comb begin
    known  = 1'b1;
    cmd.op = OP_STATUS;
    unique case (mode)
      MODE_ON:     cmd.op = OP_ON;
      MODE_OFF:    cmd.op = OP_OFF;
      MODE_STATUS: cmd.op = OP_STATUS;
      default:     known  = 1'b0;
    endcase
    cmd.note     = note;
    cmd.velocity = velocity;
    cmd.sel      = voice_sel;
    cmd.sel_ok   = (32'(voice_sel) < 32'(NUM_VOICES));
    cmd.phase    = (env_phase == PH_SOUND || env_phase == PH_REL) ? env_phase : PH_IDLE;
  end

  assign lvl_wide = {env_level, {LEVEL_BITS{1'b0}}};
  assign level    = lvl_wide[LEVEL_BITS+15:16];
  assign push     = start && !busy && known;

endmodule

// ===== src/pva_queue.sv =====
// Two-entry queue between the front end and the voice scanner.
`timescale 1ns / 1ps

module pva_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rd_data   = entries[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule

// ===== src/pva_back.sv =====
// Back end: voice table and the one-voice-per-cycle scanner.
`timescale 1ns / 1ps

module pva_back import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef,
  parameter int LEVEL_BITS = LevelBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  input  logic [LEVEL_BITS-1:0] q_level,
  output logic                  pop,
  output logic                  done,
  output logic                  kind,
  output logic                  granted,
  output logic [3:0]            voice_out,
  output logic [6:0]            note_out,
  output logic [6:0]            velocity_out,
  output logic [15:0]           release_mask
);

  localparam int VW = $clog2(NUM_VOICES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_OFF
  } state_t;

  state_t state;

  logic [7:0]            vnote  [NUM_VOICES];
  logic [1:0]            vphase [NUM_VOICES];
  logic [LEVEL_BITS-1:0] vlevel [NUM_VOICES];

  logic [VW-1:0]         cnt;
  logic [6:0]            cur_note;
  logic [6:0]            cur_vel;
  logic                  idle_found;
  logic [VW-1:0]         idle_idx;
  logic                  rel_found;
  logic [VW-1:0]         rel_idx;
  logic [LEVEL_BITS:0]   best;
  logic [NUM_VOICES-1:0] mask;

  logic                   last;
  logic                   hit;
  logic                   idle_now;
  logic                   rel_now;
  logic                   pick_ok;
  logic [VW-1:0]          pick_idx;
  logic [VW+3:0]          pick_ext;
  logic [VW+3:0]          sel_ext;
  logic [VW-1:0]          sel_idx;
  logic [NUM_VOICES-1:0]  mask_now;
  logic [NUM_VOICES+15:0] mask_ext;

  always_comb begin
    last     = (32'(cnt) == 32'(NUM_VOICES - 1));
    hit      = (vnote[cnt] == {1'b0, cur_note});
    idle_now = !idle_found && (vphase[cnt] == PH_IDLE);
    rel_now  = !idle_found && (vphase[cnt] == PH_REL) && ({1'b0, vlevel[cnt]} < best);
    pick_ok  = 1'b1;
    pick_idx = cnt;
    if (hit) begin
      pick_idx = cnt;
    end else if (idle_found) begin
      pick_idx = idle_idx;
    end else if (idle_now || rel_now) begin
      pick_idx = cnt;
    end else if (rel_found) begin
      pick_idx = rel_idx;
    end else begin
      pick_ok  = 1'b0;
      pick_idx = '0;
    end
    pick_ext = {4'b0, pick_idx};
    sel_ext  = {{VW{1'b0}}, q_cmd.sel};
    sel_idx  = sel_ext[VW-1:0];
    mask_now = mask | (hit ? ({{(NUM_VOICES-1){1'b0}}, 1'b1} << cnt) : '0);
    mask_ext = {16'b0, mask_now};
  end

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      kind         <= KIND_ON;
      granted      <= 1'b0;
      voice_out    <= '0;
      note_out     <= '0;
      velocity_out <= '0;
      release_mask <= '0;
      cnt          <= '0;
      idle_found   <= 1'b0;
      rel_found    <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        vnote[i]  <= NOTE_NONE;
        vphase[i] <= PH_IDLE;
        vlevel[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_note   <= q_cmd.note;
            cur_vel    <= q_cmd.velocity;
            cnt        <= '0;
            idle_found <= 1'b0;
            rel_found  <= 1'b0;
            best       <= {1'b1, {LEVEL_BITS{1'b0}}};
            mask       <= '0;
            unique case (q_cmd.op)
              OP_ON:  state <= S_ON;
              OP_OFF: state <= S_OFF;
              default: begin
                if (q_cmd.sel_ok) begin
                  vphase[sel_idx] <= q_cmd.phase;
                  vlevel[sel_idx] <= q_level;
                end
              end
            endcase
          end
        end
        S_ON: begin
          if (idle_now) begin
            idle_found <= 1'b1;
            idle_idx   <= cnt;
          end else if (rel_now) begin
            rel_found <= 1'b1;
            rel_idx   <= cnt;
            best      <= {1'b0, vlevel[cnt]};
          end
          cnt <= cnt + 1'b1;
          if (hit || last) begin
            if (pick_ok) begin
              vnote[pick_idx]  <= {1'b0, cur_note};
              vphase[pick_idx] <= PH_SOUND;
            end
            done         <= 1'b1;
            kind         <= KIND_ON;
            granted      <= pick_ok;
            voice_out    <= pick_ok ? pick_ext[3:0] : 4'd0;
            note_out     <= cur_note;
            velocity_out <= pick_ok ? cur_vel : 7'd0;
            release_mask <= '0;
            state        <= S_IDLE;
          end
        end
        S_OFF: begin
          if (hit) begin
            vphase[cnt] <= PH_REL;
          end
          mask <= mask_now;
          cnt  <= cnt + 1'b1;
          if (last) begin
            done         <= 1'b1;
            kind         <= KIND_OFF;
            granted      <= 1'b0;
            voice_out    <= '0;
            note_out     <= cur_note;
            velocity_out <= '0;
            release_mask <= mask_ext[15:0];
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/poly_voice_allocator.sv =====
// Top level of the polyphonic voice allocator.
// Flow: an accepted event waits in the queue behind the beats ahead of it; a note on scans
// up to the first voice holding its note or the last voice, a note off scans every voice.
// Throughput: the scanner reads one voice a cycle and takes no new beat until a note event's
// scan ends, while a status report is applied from the idle state; a two-beat queue sits ahead.
// Reset: synchronous; all voices return to no note, idle phase and zero level at once.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps

module poly_voice_allocator import pva_pkg::*; #(
  parameter int NUM_VOICES = NumVoicesDef,
  parameter int LEVEL_BITS = LevelBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [6:0]  note,
  input  logic [6:0]  velocity,
  input  logic [3:0]  voice_sel,
  input  logic [1:0]  env_phase,
  input  logic [15:0] env_level,
  output logic        done,
  output logic        kind,
  output logic        granted,
  output logic [3:0]  voice_out,
  output logic [6:0]  note_out,
  output logic [6:0]  velocity_out,
  output logic [15:0] release_mask
);

  localparam int QW = CmdBits + LEVEL_BITS;

  logic                  push;
  cmd_t                  f_cmd;
  logic [LEVEL_BITS-1:0] f_level;
  logic [QW-1:0]         q_rd;
  logic                  q_valid;
  logic                  pop;
  cmd_t                  q_cmd;
  logic [LEVEL_BITS-1:0] q_level;

  pva_front #(
    .NUM_VOICES(NUM_VOICES),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .note     (note),
    .velocity (velocity),
    .voice_sel(voice_sel),
    .env_phase(env_phase),
    .env_level(env_level),
    .push     (push),
    .cmd      (f_cmd),
    .level    (f_level)
  );

  pva_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  ({f_cmd, f_level}),
    .pop      (pop),
    .rd_data  (q_rd),
    .not_empty(q_valid),
    .full     (busy)
  );

  assign q_cmd   = cmd_t'(q_rd[QW-1:LEVEL_BITS]);
  assign q_level = q_rd[LEVEL_BITS-1:0];

  pva_back #(
    .NUM_VOICES(NUM_VOICES),
    .LEVEL_BITS(LEVEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_level     (q_level),
    .pop         (pop),
    .done        (done),
    .kind        (kind),
    .granted     (granted),
    .voice_out   (voice_out),
    .note_out    (note_out),
    .velocity_out(velocity_out),
    .release_mask(release_mask)
  );

endmodule

// ===== src/pva_checker.sv =====
// Port-level checks for the voice allocator, bound to the top level.
`timescale 1ns / 1ps

module pva_checker import pva_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        kind,
  input logic        granted,
  input logic [3:0]  voice_out,
  input logic [6:0]  velocity_out,
  input logic [15:0] release_mask
);

  a_off_fields: assert property (@(posedge clk) disable iff (rst)
    done && kind == KIND_OFF |-> !granted && voice_out == 4'd0 && velocity_out == 7'd0)
    else $error("note-off beat carries grant fields");

  a_on_mask: assert property (@(posedge clk) disable iff (rst)
    done && kind == KIND_ON |-> release_mask == 16'd0)
    else $error("note-on beat carries a release mask");

  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    done && kind == KIND_ON && !granted |-> voice_out == 4'd0 && velocity_out == 7'd0)
    else $error("refused note-on beat carries voice or velocity");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats back to back");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("queue filled without a new event");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .kind        (kind),
  .granted     (granted),
  .voice_out   (voice_out),
  .velocity_out(velocity_out),
  .release_mask(release_mask)
);
